### rtl/master_link_login_keepalive_macros.svh
// ----------------------------------------------------------------------------
// master link controller assertion macros
// shared property templates for the port checker
// ----------------------------------------------------------------------------
`ifndef MASTER_LINK_LOGIN_KEEPALIVE_MACROS_SVH
`define MASTER_LINK_LOGIN_KEEPALIVE_MACROS_SVH

// same-cycle implication, quiet during reset
`define MLK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define MLK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mlk_pkg.sv
// ----------------------------------------------------------------------------
// mlk_pkg
// codes, types and fixed widths of the master link controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlk_pkg;

  localparam int PERIOD_BITS  = 20;
  localparam int ELAPSED_BITS = 16;
  localparam int SALT_BITS    = 32;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [PERIOD_BITS-1:0] RETRY_PERIOD_RESET   = 20'd10000;
  localparam logic [PERIOD_BITS-1:0] TIMEOUT_PERIOD_RESET = 20'd600000;
  localparam logic [PERIOD_BITS-1:0] PING_PERIOD_RESET    = 20'd5000;

  typedef enum logic [2:0] {
    ST_DISC   = 3'd0,
    ST_LOGIN  = 3'd1,
    ST_AUTH   = 3'd2,
    ST_CONFIG = 3'd3,
    ST_RUN    = 3'd4
  } link_state_t;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_LOGIN  = 3'd1,
    CMD_AUTH   = 3'd2,
    CMD_CONFIG = 3'd3,
    CMD_PING   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    DROP_NONE      = 2'd0,
    DROP_REFUSED   = 2'd1,
    DROP_CLOSED    = 2'd2,
    DROP_TIMED_OUT = 2'd3
  } drop_t;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_NAK     = 3'd1,
    KIND_ACK     = 3'd2,
    KIND_CLOSE   = 3'd3,
    KIND_PONG    = 3'd4,
    KIND_BEACON  = 3'd5,
    KIND_UNKNOWN = 3'd6
  } kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RETRY   = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_PING    = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_CLOCK = 1'b0,
    OP_OPEN  = 1'b1
  } op_t;

  typedef struct packed {
    logic                    op;
    logic                    has_packet;
    logic                    from_master;
    logic [2:0]              packet_kind;
    logic [SALT_BITS-1:0]    packet_salt;
    logic [ELAPSED_BITS-1:0] elapsed_ms;
  } item_t;

  typedef struct packed {
    cmd_t                 first_send;
    cmd_t                 second_send;
    logic [SALT_BITS-1:0] auth_salt;
    link_state_t          link_state;
    logic                 frame_queued;
    drop_t                drop_event;
  } result_t;

endpackage

### rtl/mlk_timer.sv
// ----------------------------------------------------------------------------
// mlk_timer
// saturating millisecond advance and expiry compare of one link timer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlk_timer
  import mlk_pkg::*;
#(
  parameter int TIMER_BITS = 20
) (
  input  logic [TIMER_BITS-1:0]   cnt,
  input  logic                    run,
  input  logic                    tick_en,
  input  logic [ELAPSED_BITS-1:0] ms,
  input  logic [PERIOD_BITS-1:0]  period,
  output logic [TIMER_BITS-1:0]   cnt_ticked,
  output logic                    expired
);

  localparam int CMP_BITS = (TIMER_BITS > PERIOD_BITS) ? TIMER_BITS : PERIOD_BITS;

  logic [TIMER_BITS:0] sum;
  logic                active;

  assign active = tick_en & run;
  assign sum    = {1'b0, cnt} + (TIMER_BITS+1)'(ms);

  // saturate at all ones on carry out
  assign cnt_ticked = !active ? cnt :
                      (sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0]);

  assign expired = active && (period != '0) &&
                   (CMP_BITS'(cnt_ticked) >= CMP_BITS'(period));

endmodule

### rtl/master_link_login_keepalive.sv
// ----------------------------------------------------------------------------
// master_link_login_keepalive
// repeater-side login, retry, keepalive and timeout control of a master link
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    op has_packet from_master packet_kind
//                                    packet_salt elapsed_ms
// out      out  out_valid/out_ready  first_send second_send auth_salt
//                                    link_state frame_queued drop_event
// cfg      in   cfg_valid/cfg_ready  cfg_index cfg_data
//
// one beat per cycle sustained while out_ready holds; an accepted beat waits in
// the input register, its result then drives out_valid from the result register
// the whole state update (three timer adds and compares) sits between the two
// registers; a stalled result register holds both stages, and in_ready stays
// high while the input register is empty or moving on
// rst clears the link state, timers and salt and restores the default periods
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module master_link_login_keepalive
  import mlk_pkg::*;
#(
  parameter int TIMER_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  // item channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    op,
  input  logic                    has_packet,
  input  logic                    from_master,
  input  logic [2:0]              packet_kind,
  input  logic [SALT_BITS-1:0]    packet_salt,
  input  logic [ELAPSED_BITS-1:0] elapsed_ms,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              first_send,
  output logic [2:0]              second_send,
  output logic [SALT_BITS-1:0]    auth_salt,
  output logic [2:0]              link_state,
  output logic                    frame_queued,
  output logic [1:0]              drop_event,
  // register write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [PERIOD_BITS-1:0]  cfg_data
);

  localparam logic [TIMER_BITS-1:0] CNT_START = TIMER_BITS'(1);

  // configuration registers
  logic [PERIOD_BITS-1:0] retry_period;
  logic [PERIOD_BITS-1:0] timeout_period;
  logic [PERIOD_BITS-1:0] ping_period;

  // link state
  link_state_t            link_status;
  logic [SALT_BITS-1:0]   salt_word;
  logic [TIMER_BITS-1:0]  retry_count;
  logic                   retry_running;
  logic [TIMER_BITS-1:0]  timeout_count;
  logic                   timeout_running;
  logic [TIMER_BITS-1:0]  ping_count;
  logic                   ping_running;

  // pipeline registers
  logic    stage_valid;
  item_t   stage;
  logic    res_valid;
  result_t res;

  logic advance;
  logic stage_ready;

  // next state
  link_state_t           link_status_next;
  logic [SALT_BITS-1:0]  salt_word_next;
  logic [TIMER_BITS-1:0] retry_count_next;
  logic                  retry_running_next;
  logic [TIMER_BITS-1:0] timeout_count_next;
  logic                  timeout_running_next;
  logic [TIMER_BITS-1:0] ping_count_next;
  logic                  ping_running_next;
  result_t               res_next;

  // values after packet handling, before the clock advance
  link_state_t           st_pkt;
  logic [TIMER_BITS-1:0] rt_cnt_pkt, to_cnt_pkt, pg_cnt_pkt;
  logic                  rt_run_pkt, to_run_pkt, pg_run_pkt;
  cmd_t                  first_cmd;
  logic                  queued;
  drop_t                 drop_pkt;

  logic                  clock_call;
  logic                  rt_tick_en, pg_tick_en;
  logic [TIMER_BITS-1:0] rt_cnt_tick, to_cnt_tick, pg_cnt_tick;
  logic                  rt_expired, to_expired, pg_expired;

  // ---------------------------------------------------------------------------
  // handshakes: result register gates everything behind it
  // ---------------------------------------------------------------------------
  assign advance     = !res_valid || out_ready;
  assign stage_ready = !stage_valid || advance;
  assign in_ready    = stage_ready;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && in_valid) begin
      stage <= '{op: op, has_packet: has_packet, from_master: from_master,
                 packet_kind: packet_kind, packet_salt: packet_salt,
                 elapsed_ms: elapsed_ms};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_period   <= RETRY_PERIOD_RESET;
      timeout_period <= TIMEOUT_PERIOD_RESET;
      ping_period    <= PING_PERIOD_RESET;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_RETRY:   retry_period   <= cfg_data;
        REG_TIMEOUT: timeout_period <= cfg_data;
        REG_PING:    ping_period    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // open request and packet handling
  // ---------------------------------------------------------------------------
  assign clock_call = (op_t'(stage.op) == OP_CLOCK);

  always_comb begin
    st_pkt         = link_status;
    salt_word_next = salt_word;
    rt_cnt_pkt     = retry_count;
    rt_run_pkt     = retry_running;
    to_cnt_pkt     = timeout_count;
    to_run_pkt     = timeout_running;
    pg_cnt_pkt     = ping_count;
    pg_run_pkt     = ping_running;
    first_cmd      = CMD_NONE;
    queued         = 1'b0;
    drop_pkt       = DROP_NONE;

    if (!clock_call) begin
      // open restarts login from any state, no time passes
      first_cmd  = CMD_LOGIN;
      st_pkt     = ST_LOGIN;
      to_cnt_pkt = CNT_START;
      to_run_pkt = 1'b1;
      rt_cnt_pkt = CNT_START;
      rt_run_pkt = 1'b1;
    end else if (stage.has_packet && stage.from_master) begin
      case (kind_t'(stage.packet_kind))
        KIND_DATA: begin
          queued = 1'b1;
        end
        KIND_NAK, KIND_CLOSE: begin
          st_pkt     = ST_DISC;
          to_cnt_pkt = '0;
          to_run_pkt = 1'b0;
          rt_cnt_pkt = '0;
          rt_run_pkt = 1'b0;
          drop_pkt   = (kind_t'(stage.packet_kind) == KIND_NAK) ? DROP_REFUSED : DROP_CLOSED;
        end
        KIND_ACK: begin
          case (link_status)
            ST_LOGIN: begin
              salt_word_next = stage.packet_salt;
              first_cmd      = CMD_AUTH;
              st_pkt         = ST_AUTH;
              to_cnt_pkt     = CNT_START;
              to_run_pkt     = 1'b1;
              rt_cnt_pkt     = CNT_START;
              rt_run_pkt     = 1'b1;
            end
            ST_AUTH: begin
              first_cmd  = CMD_CONFIG;
              st_pkt     = ST_CONFIG;
              to_cnt_pkt = CNT_START;
              to_run_pkt = 1'b1;
              rt_cnt_pkt = CNT_START;
              rt_run_pkt = 1'b1;
            end
            ST_CONFIG: begin
              // login done: retry off, keepalive on
              st_pkt     = ST_RUN;
              to_cnt_pkt = CNT_START;
              to_run_pkt = 1'b1;
              rt_cnt_pkt = '0;
              rt_run_pkt = 1'b0;
              pg_cnt_pkt = CNT_START;
              pg_run_pkt = 1'b1;
            end
            default: ;
          endcase
        end
        KIND_PONG: begin
          // restarts the timeout even while disconnected
          to_cnt_pkt = CNT_START;
          to_run_pkt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // clock advance: retry runs outside the running state, ping inside it
  // ---------------------------------------------------------------------------
  assign rt_tick_en = clock_call && (st_pkt != ST_RUN);
  assign pg_tick_en = clock_call && (st_pkt == ST_RUN);

  mlk_timer #(.TIMER_BITS(TIMER_BITS)) u_retry_timer (
    .cnt        (rt_cnt_pkt),
    .run        (rt_run_pkt),
    .tick_en    (rt_tick_en),
    .ms         (stage.elapsed_ms),
    .period     (retry_period),
    .cnt_ticked (rt_cnt_tick),
    .expired    (rt_expired)
  );

  mlk_timer #(.TIMER_BITS(TIMER_BITS)) u_ping_timer (
    .cnt        (pg_cnt_pkt),
    .run        (pg_run_pkt),
    .tick_en    (pg_tick_en),
    .ms         (stage.elapsed_ms),
    .period     (ping_period),
    .cnt_ticked (pg_cnt_tick),
    .expired    (pg_expired)
  );

  mlk_timer #(.TIMER_BITS(TIMER_BITS)) u_timeout_timer (
    .cnt        (to_cnt_pkt),
    .run        (to_run_pkt),
    .tick_en    (clock_call),
    .ms         (stage.elapsed_ms),
    .period     (timeout_period),
    .cnt_ticked (to_cnt_tick),
    .expired    (to_expired)
  );

  // ---------------------------------------------------------------------------
  // expiry actions and the result beat
  // ---------------------------------------------------------------------------
  always_comb begin
    cmd_t  second_cmd;
    drop_t drop_code;

    link_status_next     = st_pkt;
    retry_count_next     = rt_cnt_tick;
    retry_running_next   = rt_run_pkt;
    ping_count_next      = pg_cnt_tick;
    ping_running_next    = pg_run_pkt;
    timeout_count_next   = to_cnt_tick;
    timeout_running_next = to_run_pkt;
    second_cmd           = CMD_NONE;
    drop_code            = drop_pkt;

    // resend the pending login step; nothing to resend while disconnected
    if (rt_expired) begin
      case (st_pkt)
        ST_LOGIN:  second_cmd = CMD_LOGIN;
        ST_AUTH:   second_cmd = CMD_AUTH;
        ST_CONFIG: second_cmd = CMD_CONFIG;
        default:   second_cmd = CMD_NONE;
      endcase
      retry_count_next   = CNT_START;
      retry_running_next = 1'b1;
    end

    if (pg_expired) begin
      second_cmd        = CMD_PING;
      ping_count_next   = CNT_START;
      ping_running_next = 1'b1;
    end

    // no ack or pong in time: drop, ping timer is left alone
    if (to_expired) begin
      link_status_next     = ST_DISC;
      timeout_count_next   = '0;
      timeout_running_next = 1'b0;
      retry_count_next     = '0;
      retry_running_next   = 1'b0;
      drop_code            = DROP_TIMED_OUT;
    end

    res_next = '{first_send: first_cmd, second_send: second_cmd,
                 auth_salt: salt_word_next, link_state: link_status_next,
                 frame_queued: queued, drop_event: drop_code};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_status     <= ST_DISC;
      salt_word       <= '0;
      retry_count     <= '0;
      retry_running   <= 1'b0;
      timeout_count   <= '0;
      timeout_running <= 1'b0;
      ping_count      <= '0;
      ping_running    <= 1'b0;
    end else if (stage_valid && advance) begin
      link_status     <= link_status_next;
      salt_word       <= salt_word_next;
      retry_count     <= retry_count_next;
      retry_running   <= retry_running_next;
      timeout_count   <= timeout_count_next;
      timeout_running <= timeout_running_next;
      ping_count      <= ping_count_next;
      ping_running    <= ping_running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      res <= res_next;
    end
  end

  assign out_valid    = res_valid;
  assign first_send   = res.first_send;
  assign second_send  = res.second_send;
  assign auth_salt    = res.auth_salt;
  assign link_state   = res.link_state;
  assign frame_queued = res.frame_queued;
  assign drop_event   = res.drop_event;

endmodule

### rtl/mlk_checker.sv
// ----------------------------------------------------------------------------
// mlk_checker
// port-level checks of the master link controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "master_link_login_keepalive_macros.svh"

module mlk_checker
  import mlk_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] first_send,
  input logic [2:0] second_send,
  input logic [2:0] link_state,
  input logic       frame_queued,
  input logic [1:0] drop_event
);

  // a result beat is held until taken
  `MLK_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result beat dropped while stalled")

  // every disconnect event leaves the link down
  `MLK_ASSERT_NOW(a_drop_disc, clk, rst, out_valid && (drop_event != DROP_NONE), link_state == ST_DISC, "drop event without disconnected state")

  // a data frame never comes with a login step command
  `MLK_ASSERT_NOW(a_frame_no_cmd, clk, rst, out_valid && frame_queued, first_send == CMD_NONE, "frame queued with a first command")

  // pings go out only while running, unless the same beat timed out
  `MLK_ASSERT_NOW(a_ping_run, clk, rst, out_valid && (second_send == CMD_PING), (link_state == ST_RUN) || (drop_event == DROP_TIMED_OUT), "ping outside running state")

endmodule

bind master_link_login_keepalive mlk_checker u_mlk_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .first_send   (first_send),
  .second_send  (second_send),
  .link_state   (link_state),
  .frame_queued (frame_queued),
  .drop_event   (drop_event)
);
